@@ hdl/tcw_pkg.sv @@
// Shared types, widths and constants of the text console writer.
`default_nettype none

package tcw_pkg;

    // Default screen geometry.
    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    // Fixed field widths.
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int ATTR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int POS_W   = 12;
    localparam int CELL_W  = 16;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [POS_W-1:0]  HIDDEN_POS = 12'd4000;
    localparam logic [CHAR_W-1:0] NEWLINE    = 8'h0A;

    // What the result register is loaded with.
    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_PUT  = 2'd1,
        RES_READ = 2'd2,
        RES_MISS = 2'd3
    } t_res_kind;

    typedef struct packed {
        logic      latch;
        logic      sweep_clr;
        logic      fill;
        logic      scroll;
        logic      cur_scroll;
        logic      cur_newline;
        logic      cur_home;
        logic      put_write;
        logic      res_load;
        t_res_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              is_newline;
        logic              row_past;
        logic              col_past;
        logic              rd_in_range;
        logic              sweep_last;
    } t_dp_status;

endpackage

`default_nettype wire

@@ hdl/tcw_if.sv @@
// Valid/ready channel interfaces for the console input and result streams.
`default_nettype none

interface tcw_in_if;
    import tcw_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [IDX_W-1:0]   read_index;

    modport source (
        output valid, func, char_code, fg_color, bg_color, read_index,
        input  ready
    );
    modport sink (
        input  valid, func, char_code, fg_color, bg_color, read_index,
        output ready
    );
endinterface

interface tcw_out_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic              cell_written;
    logic [IDX_W-1:0]  cell_index;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [POS_W-1:0]  cursor_pos;

    modport source (
        output valid, cell_written, cell_index, cell_char, cell_attr, cursor_pos,
        input  ready
    );
    modport sink (
        input  valid, cell_written, cell_index, cell_char, cell_attr, cursor_pos,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/text_console_writer_top.sv @@
// Top level of the text console writer: controller, datapath and channel hookup.
//
//   Channel   Direction  Handshake        Carries
//   i_in      sink       valid / ready    func, char_code, fg_color, bg_color, read_index
//   o_out     source     valid / ready    cell_written, cell_index, cell_char,
//                                         cell_attr, cursor_pos
//   cfg       input      i_cfg_we         i_cfg_wdata = cursor_visible
//
// A put of a printable character or a newline is an accept and then one decode step;
// a wrapping put adds a decode step, and a read in range adds a memory read step.
// A clear is a sweep of the cell store and each scroll adds another sweep. The store
// has one write port and one read port; a sweep covers one cell per cycle.
// After reset the same sweep blanks the store, and the input is not ready until it ends.
// One result register holds a finished transaction; the next one is accepted in the cycle
// that result is taken, so a stalled output only stalls the input.
`default_nettype none

module text_console_writer_top #(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    tcw_in_if.sink     i_in,
    tcw_out_if.source  o_out
);
    import tcw_pkg::*;

    // Command and status between the controller and the datapath.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // The controller owns the handshakes; the datapath owns every payload bit,
    // including the result register that sits on the output channel.
    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The cursor is kept both as column/row and as a linear position, so
    // neither the write address nor the reported position needs a multiplier.
    tcw_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (i_in.func),
        .i_char_code    (i_in.char_code),
        .i_fg_color     (i_in.fg_color),
        .i_bg_color     (i_in.bg_color),
        .i_read_index   (i_in.read_index),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_cell_written (o_out.cell_written),
        .o_cell_index   (o_out.cell_index),
        .o_cell_char    (o_out.cell_char),
        .o_cell_attr    (o_out.cell_attr),
        .o_cursor_pos   (o_out.cursor_pos)
    );

endmodule

`default_nettype wire

@@ hdl/tcw_dp.sv @@
// Datapath: cell store, cursor, sweep counter, scroll copy stage and result register.
`default_nettype none

module tcw_dp #(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    input  wire logic [tcw_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  wire logic [tcw_pkg::COLOR_W-1:0]   i_fg_color,
    input  wire logic [tcw_pkg::COLOR_W-1:0]   i_bg_color,
    input  wire logic [tcw_pkg::IDX_W-1:0]     i_read_index,
    input  wire tcw_pkg::t_dp_cmd              i_cmd,
    output tcw_pkg::t_dp_status                o_status,
    output logic                               o_cell_written,
    output logic [tcw_pkg::IDX_W-1:0]          o_cell_index,
    output logic [tcw_pkg::CHAR_W-1:0]         o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]         o_cell_attr,
    output logic [tcw_pkg::POS_W-1:0]          o_cursor_pos
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int MOVE   = (ROWS - 1) * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int LIN_W  = $clog2(CELLS + COLS + 1);

    // Latched item fields.
    logic [FUNC_W-1:0]  r_func;
    logic [CHAR_W-1:0]  r_char;
    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    logic [IDX_W-1:0]   r_read_index;

    // Cursor: column, row and the linear position row*COLS+col kept alongside.
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [LIN_W-1:0] r_lin, n_lin;
    logic             r_vis;

    logic [ADDR_W-1:0] r_cnt;

    // Delayed write stage of the scroll copy.
    logic              r_sc_wv;
    logic [ADDR_W-1:0] r_sc_wa;
    logic              r_sc_blank;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_cnt_blank;
    logic [ADDR_W:0]   w_src_sum;
    logic [ATTR_W-1:0] w_attr;

    logic [ADDR_W+IDX_W-1:0] w_ridx_ext;
    logic [LIN_W+IDX_W-1:0]  w_lin_idx;
    logic [LIN_W+POS_W-1:0]  w_lin_pos;

    assign w_attr      = {r_bg, r_fg};
    assign w_cnt_blank = (32'(r_cnt) >= 32'(MOVE));
    assign w_src_sum   = (ADDR_W + 1)'(r_cnt) + (ADDR_W + 1)'(COLS);
    assign w_ridx_ext  = {{ADDR_W{1'b0}}, r_read_index};
    assign w_lin_idx   = {{IDX_W{1'b0}}, r_lin};
    assign w_lin_pos   = {{POS_W{1'b0}}, n_lin};

    assign o_status.func        = r_func;
    assign o_status.is_newline  = (r_char == NEWLINE);
    assign o_status.row_past    = (r_row >= ROW_W'(ROWS));
    assign o_status.col_past    = (r_col >= COL_W'(COLS));
    assign o_status.rd_in_range = ({{(32-IDX_W){1'b0}}, r_read_index} < 32'(CELLS));
    assign o_status.sweep_last  = (r_cnt == ADDR_W'(CELLS - 1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_lin = r_lin;
        if (i_cmd.cur_home) begin
            n_col = COL_W'(1);
            n_row = '0;
            n_lin = LIN_W'(1);
        end else if (i_cmd.cur_scroll) begin
            n_row = ROW_W'(ROWS - 1);
            n_lin = r_lin - LIN_W'(COLS);
        end else if (i_cmd.cur_newline) begin
            n_col = COL_W'(1);
            n_row = r_row + ROW_W'(1);
            n_lin = r_lin + LIN_W'(COLS + 1) - LIN_W'(r_col);
        end else if (i_cmd.put_write) begin
            n_col = r_col + COL_W'(1);
            n_lin = r_lin + LIN_W'(1);
        end
    end

    // One write port: scroll copy first, then the sweep fill, then a character.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_lin[ADDR_W-1:0];
        w_wdata = {w_attr, r_char};
        if (r_sc_wv) begin
            w_we    = 1'b1;
            w_waddr = r_sc_wa;
            w_wdata = r_sc_blank ? BLANK_CELL : r_rdata;
        end else if (i_cmd.fill) begin
            w_we    = 1'b1;
            w_waddr = r_cnt;
            w_wdata = BLANK_CELL;
        end else if (i_cmd.put_write) begin
            w_we = 1'b1;
        end
    end

    always_comb begin
        if (i_cmd.scroll) begin
            w_raddr = w_cnt_blank ? r_cnt : w_src_sum[ADDR_W-1:0];
        end else begin
            w_raddr = w_ridx_ext[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func       <= i_func;
            r_char       <= i_char_code;
            r_fg         <= i_fg_color;
            r_bg         <= i_bg_color;
            r_read_index <= i_read_index;
        end
        r_sc_wa    <= r_cnt;
        r_sc_blank <= w_cnt_blank;
        if (i_cmd.res_load) begin
            o_cursor_pos <= r_vis ? w_lin_pos[POS_W-1:0] : HIDDEN_POS;
            case (i_cmd.res_kind)
                RES_PUT: begin
                    o_cell_written <= 1'b1;
                    o_cell_index   <= w_lin_idx[IDX_W-1:0];
                    o_cell_char    <= r_char;
                    o_cell_attr    <= w_attr;
                end
                RES_READ: begin
                    o_cell_written <= 1'b0;
                    o_cell_index   <= r_read_index;
                    o_cell_char    <= r_rdata[CHAR_W-1:0];
                    o_cell_attr    <= r_rdata[CELL_W-1:CHAR_W];
                end
                RES_MISS: begin
                    o_cell_written <= 1'b0;
                    o_cell_index   <= r_read_index;
                    o_cell_char    <= '0;
                    o_cell_attr    <= '0;
                end
                default: begin
                    o_cell_written <= 1'b0;
                    o_cell_index   <= '0;
                    o_cell_char    <= '0;
                    o_cell_attr    <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_lin   <= '0;
            r_vis   <= 1'b1;
            r_cnt   <= '0;
            r_sc_wv <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_lin   <= n_lin;
            r_sc_wv <= i_cmd.scroll;
            if (i_cfg_we) begin
                r_vis <= i_cfg_wdata;
            end
            if (i_cmd.sweep_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.fill || i_cmd.scroll) begin
                r_cnt <= r_cnt + ADDR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
// Controller: sequences each item and the clearing and scrolling sweeps.
`default_nettype none

module tcw_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    input  wire tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_dp_cmd         o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECODE = 7'b0000100,
        S_SCROLL = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_READ   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.res_kind = RES_NONE;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.func)
                    FUNC_PUT: begin
                        if (i_status.row_past) begin
                            o_cmd.sweep_clr = 1'b1;
                            n_state         = S_SCROLL;
                        end else if (i_status.is_newline) begin
                            o_cmd.cur_newline = 1'b1;
                            o_cmd.res_load    = 1'b1;
                            n_state           = S_IDLE;
                        end else if (i_status.col_past) begin
                            // Wrap to the next row; a scroll may follow.
                            o_cmd.cur_newline = 1'b1;
                        end else begin
                            o_cmd.put_write = 1'b1;
                            o_cmd.res_load  = 1'b1;
                            o_cmd.res_kind  = RES_PUT;
                            n_state         = S_IDLE;
                        end
                    end
                    FUNC_CLEAR: begin
                        o_cmd.sweep_clr = 1'b1;
                        n_state         = S_CLEAR;
                    end
                    FUNC_READ: begin
                        if (i_status.rd_in_range) begin
                            n_state = S_READ;
                        end else begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_kind = RES_MISS;
                            n_state        = S_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                endcase
            end
            S_SCROLL: begin
                o_cmd.scroll = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.cur_scroll = 1'b1;
                n_state          = S_DECODE;
            end
            S_CLEAR: begin
                o_cmd.fill = 1'b1;
                if (i_status.sweep_last) begin
                    o_cmd.cur_home = 1'b1;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = RES_READ;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.res_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire
